// ===== design/puc_pkg.sv =====
// Shared types and constants of the pixel replication upscaler.
`default_nettype none

package puc_pkg;

    // Default line buffer depth in pixels
    localparam int MAX_WIDTH_DEFAULT = 1024;

    // Largest effective scale factor
    localparam logic [6:0] SCALE_MAX = 7'd100;

    // Result queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SCALE_FACTOR = 1'b0;
    localparam logic CFG_SOURCE_WIDTH = 1'b1;

    // One emitted run
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [6:0] repeat_count;
        logic [1:0] pad_bytes;
        logic       row_end;
        logic       rejected;
    } result_t;

endpackage

`default_nettype wire

// ===== design/puc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module puc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/puc_front.sv =====
// Front part: configuration, item classification, row state and line buffer.
`default_nettype none

module puc_front
    import puc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [10:0]         cfg_data,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                operation,
    input  wire logic [7:0]          blue,
    input  wire logic [7:0]          green,
    input  wire logic [7:0]          red,
    // queue side
    input  wire logic [QUEUE_CW-1:0] q_count,
    output logic                     push,
    output result_t                  push_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

    logic [6:0]    scale_factor_reg;
    logic [10:0]   source_width_reg;
    logic [CW-1:0] column_reg, column_next;
    logic [6:0]    replays_left_reg, replays_left_next;
    logic          replaying_reg, replaying_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_replay_reg, s1_replay_next;
    result_t       s1_res_reg, s1_res_next;

    logic [6:0]    eff_f;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] sw_ext;
    logic [EW-1:0] col_p1;
    logic [3:0]    pad_prod;
    logic [1:0]    row_pad;
    logic          last;
    logic          accept;
    logic [QUEUE_CW:0] occupancy;
    logic          wr_en;
    logic          rd_en;
    logic [6:0]    rl_dec;
    logic [23:0]   rd_data;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= 7'd1;
            source_width_reg <= 11'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE_FACTOR: scale_factor_reg <= cfg_data[6:0];
                CFG_SOURCE_WIDTH: source_width_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp the factor and width to their usable ranges
    always_comb
    begin
        sw_ext = EW'(source_width_reg);
        if (scale_factor_reg == 7'd0)
            eff_f = 7'd1;
        else if (scale_factor_reg > SCALE_MAX)
            eff_f = SCALE_MAX;
        else
            eff_f = scale_factor_reg;
        if (source_width_reg == 11'd0)
            eff_w = EW'(1);
        else if (sw_ext > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = sw_ext;
    end

    // Row padding: (-3*w*f) mod 4 reduces to (w*f) mod 4
    assign pad_prod = {2'b00, eff_w[1:0]} * {2'b00, eff_f[1:0]};
    assign row_pad  = pad_prod[1:0];

    assign col_p1 = EW'(column_reg) + EW'(1);
    assign last   = (col_p1 >= eff_w);
    assign rl_dec = (replays_left_reg != 7'd0) ? replays_left_reg - 7'd1 : 7'd0;

    // Hold input while the queue cannot take one more result
    assign occupancy = (QUEUE_CW + 1)'(q_count) + (QUEUE_CW + 1)'(s1_valid_reg);
    assign in_stall  = (occupancy >= (QUEUE_CW + 1)'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;

    // Classify the item and advance the row state
    always_comb
    begin
        column_next       = column_reg;
        replays_left_next = replays_left_reg;
        replaying_next    = replaying_reg;
        s1_valid_next     = 1'b0;
        s1_replay_next    = s1_replay_reg;
        s1_res_next       = s1_res_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        if (accept)
        begin
            if (operation == OP_PIXEL)
            begin
                s1_valid_next  = 1'b1;
                s1_replay_next = 1'b0;
                if (replaying_reg)
                begin
                    s1_res_next          = '0;
                    s1_res_next.rejected = 1'b1;
                end
                else
                begin
                    wr_en                    = 1'b1;
                    s1_res_next.blue         = blue;
                    s1_res_next.green        = green;
                    s1_res_next.red          = red;
                    s1_res_next.repeat_count = eff_f;
                    s1_res_next.pad_bytes    = last ? row_pad : 2'd0;
                    s1_res_next.row_end      = last;
                    s1_res_next.rejected     = 1'b0;
                    column_next              = last ? '0 : col_p1[CW-1:0];
                    if (last && (eff_f > 7'd1))
                    begin
                        replays_left_next = eff_f - 7'd1;
                        replaying_next    = 1'b1;
                    end
                end
            end
            else if (replaying_reg)
            begin
                rd_en                    = 1'b1;
                s1_valid_next            = 1'b1;
                s1_replay_next           = 1'b1;
                s1_res_next.blue         = 8'd0;
                s1_res_next.green        = 8'd0;
                s1_res_next.red          = 8'd0;
                s1_res_next.repeat_count = eff_f;
                s1_res_next.pad_bytes    = last ? row_pad : 2'd0;
                s1_res_next.row_end      = last;
                s1_res_next.rejected     = 1'b0;
                column_next              = last ? '0 : col_p1[CW-1:0];
                if (last)
                begin
                    replays_left_next = rl_dec;
                    if (rl_dec == 7'd0)
                        replaying_next = 1'b0;
                end
            end
        end
    end

    // Hold row state and the stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg       <= '0;
            replays_left_reg <= 7'd0;
            replaying_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_replay_reg    <= 1'b0;
        end
        else
        begin
            column_reg       <= column_next;
            replays_left_reg <= replays_left_next;
            replaying_reg    <= replaying_next;
            s1_valid_reg     <= s1_valid_next;
            s1_replay_reg    <= s1_replay_next;
        end
    end

    // Payload of the stage register
    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
    end

    // Line buffer
    puc_ram #(
        .WIDTH(24),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(column_reg),
        .wr_data({red, green, blue}),
        .rd_en  (rd_en),
        .rd_addr(column_reg),
        .rd_data(rd_data)
    );

    // Merge the buffered pixel into replayed runs
    always_comb
    begin
        push_data = s1_res_reg;
        if (s1_replay_reg)
        begin
            push_data.blue  = rd_data[7:0];
            push_data.green = rd_data[15:8];
            push_data.red   = rd_data[23:16];
        end
    end

    assign push = s1_valid_reg;

endmodule

`default_nettype wire

// ===== design/puc_queue.sv =====
// Back part: result queue that presents runs on the output channel.
`default_nettype none

module puc_queue
    import puc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  result_t                  push_data,
    output logic [QUEUE_CW-1:0]      q_count,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output result_t                  head
);

    result_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = entries_reg[rd_ptr_reg];
    assign q_count   = count_reg;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/pixel_replication_upscaler_core.sv =====
// Top level of the pixel replication upscaler.
`default_nettype none

// Nearest-neighbor integer upscaler for 24-bit pixel rows. Each source pixel
// (operation 0) is stored in a line buffer of MAX_WIDTH entries and emitted
// at once as a run of scale_factor copies; the run that closes a row carries
// the padding that aligns the output row to 4 bytes. Tick items (operation 1)
// replay the stored row scale_factor-1 more times, one run per tick; a pixel
// sent during a replay comes back rejected, and a tick outside a replay gives
// no result. The block takes one item per clock while in_stall is low:
// every item finishes in one pass through the front stage, whose single
// line buffer read port serves replays. A result passes through the front
// stage register and then the four-entry result queue before it can leave,
// and input is held while the stage register and the queue together hold
// four results. The line buffer needs no clearing after reset.
// Write scale_factor (index 0) and source_width (index 1) only while idle.
module pixel_replication_upscaler_core
    import puc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_green,
    output logic [7:0]       out_red,
    output logic [6:0]       repeat_count,
    output logic [1:0]       pad_bytes,
    output logic             row_end,
    output logic             rejected
);

    logic [QUEUE_CW-1:0] q_count;
    logic                push;
    result_t             push_data;
    result_t             head;

    puc_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .blue     (blue),
        .green    (green),
        .red      (red),
        .q_count  (q_count),
        .push     (push),
        .push_data(push_data)
    );

    puc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .q_count  (q_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head     (head)
    );

    assign out_blue     = head.blue;
    assign out_green    = head.green;
    assign out_red      = head.red;
    assign repeat_count = head.repeat_count;
    assign pad_bytes    = head.pad_bytes;
    assign row_end      = head.row_end;
    assign rejected     = head.rejected;

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("result queue overfilled");

    // A push into a full queue would lose a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && (q_count == QUEUE_CW'(QUEUE_DEPTH))) |-> (out_valid && !out_stall))
    else $error("push into full queue");

    // Rejected results carry no run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (repeat_count == 7'd0 && !row_end && pad_bytes == 2'd0))
    else $error("rejected result carries a run");

    // Accepted runs repeat between 1 and the maximum factor
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rejected) |-> (repeat_count != 7'd0 && repeat_count <= SCALE_MAX))
    else $error("run repeat count out of range");

    // Padding only closes a row
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pad_bytes != 2'd0) |-> row_end)
    else $error("padding outside row end");

endmodule

`default_nettype wire

// ===== tb/upscaler_run_check.sv =====
// Run predictor and result checker for the pixel replication upscaler.
`timescale 1ns / 100ps

module upscaler_run_check
    import puc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  out_blue,
    input  wire logic [7:0]  out_green,
    input  wire logic [7:0]  out_red,
    input  wire logic [6:0]  repeat_count,
    input  wire logic [1:0]  pad_bytes,
    input  wire logic        row_end,
    input  wire logic        rejected,
    output int               mismatches,
    output int               runs_outstanding
);

    // Predicted block state
    logic [23:0] row_mem [0:MAX_WIDTH_DEFAULT-1];
    logic [9:0]  col;
    logic [6:0]  replays_left;
    logic        replaying;
    logic [6:0]  scale_reg;
    logic [10:0] width_reg;
    result_t     runs_due[$];
    int          errs;

    function automatic int scale_used();
        if (scale_reg == 7'd0) return 1;
        if (scale_reg > SCALE_MAX) return int'(SCALE_MAX);
        return int'(scale_reg);
    endfunction

    function automatic int width_used();
        if (width_reg == 11'd0) return 1;
        if (width_reg > 11'(MAX_WIDTH_DEFAULT)) return MAX_WIDTH_DEFAULT;
        return int'(width_reg);
    endfunction

    // Queue the run for px at the current column, then advance the column
    task automatic emit_run(input logic [23:0] px, output logic closed);
        int      w;
        int      f;
        result_t r;
        w = width_used();
        f = scale_used();
        closed = (int'(col) + 1 >= w);
        r.blue         = px[7:0];
        r.green        = px[15:8];
        r.red          = px[23:16];
        r.repeat_count = 7'(f);
        r.pad_bytes    = closed ? 2'((4 - (3 * w * f) % 4) % 4) : 2'd0;
        r.row_end      = closed;
        r.rejected     = 1'b0;
        runs_due.push_back(r);
        col = closed ? 10'd0 : col + 10'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t got;
        result_t want;
        logic    closed;
        if (!rst_n)
        begin
            col          = 10'd0;
            replays_left = 7'd0;
            replaying    = 1'b0;
            scale_reg    = 7'd1;
            width_reg    = 11'd1;
            errs         = 0;
            runs_due.delete();
        end
        else
        begin
            // Compare a delivered run with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = {out_blue, out_green, out_red, repeat_count, pad_bytes, row_end,
                       rejected};
                if (runs_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected run b=%h g=%h r=%h n=%0d pad=%0d end=%b rej=%b",
                                 $time, got.blue, got.green, got.red, got.repeat_count,
                                 got.pad_bytes, got.row_end, got.rejected);
                end
                else
                begin
                    want = runs_due.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"%0t: run mismatch: expected b=%h g=%h r=%h n=%0d ",
                                      "pad=%0d end=%b rej=%b, got b=%h g=%h r=%h n=%0d ",
                                      "pad=%0d end=%b rej=%b"},
                                     $time, want.blue, want.green, want.red,
                                     want.repeat_count, want.pad_bytes, want.row_end,
                                     want.rejected, got.blue, got.green, got.red,
                                     got.repeat_count, got.pad_bytes, got.row_end,
                                     got.rejected);
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SCALE_FACTOR)
                    scale_reg = cfg_data[6:0];
                else
                    width_reg = cfg_data;
            end

            // Predict the run caused by an accepted transaction
            if (in_valid && !in_stall)
            begin
                if (operation == OP_PIXEL)
                begin
                    if (replaying)
                    begin
                        want          = '0;
                        want.rejected = 1'b1;
                        runs_due.push_back(want);
                    end
                    else
                    begin
                        row_mem[col] = {red, green, blue};
                        emit_run({red, green, blue}, closed);
                        if (closed && scale_used() > 1)
                        begin
                            replays_left = 7'(scale_used() - 1);
                            replaying    = 1'b1;
                        end
                    end
                end
                else if (replaying)
                begin
                    emit_run(row_mem[col], closed);
                    if (closed)
                    begin
                        if (replays_left != 7'd0)
                            replays_left--;
                        if (replays_left == 7'd0)
                            replaying = 1'b0;
                    end
                end
            end
        end
        mismatches       <= errs;
        runs_outstanding <= runs_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the pixel replication upscaler: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb;
    import puc_pkg::*;

    localparam int ITEM_TARGET  = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_TICKS = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [6:0]  repeat_count;
    logic [1:0]  pad_bytes;
    logic        row_end;
    logic        rejected;
    int          mismatches;
    int          runs_outstanding;

    // Stimulus bookkeeping
    int          items_sent = 0;
    logic        in_calm    = 1'b0;
    logic        fill_on    = 1'b0;
    logic [7:0]  fill       = 8'h00;
    logic        hold_req   = 1'b0;
    logic        hold_done  = 1'b0;
    logic [6:0]  scale_set  = 7'd1;
    logic [10:0] width_set  = 11'd1;
    int          quiet      = 0;

    always #6 clk = ~clk;

    pixel_replication_upscaler_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .blue(blue), .green(green), .red(red),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
        .repeat_count(repeat_count), .pad_bytes(pad_bytes),
        .row_end(row_end), .rejected(rejected)
    );

    upscaler_run_check run_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .blue(blue), .green(green), .red(red),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
        .repeat_count(repeat_count), .pad_bytes(pad_bytes),
        .row_end(row_end), .rejected(rejected),
        .mismatches(mismatches), .runs_outstanding(runs_outstanding)
    );

    function automatic int eff_scale(input logic [6:0] s);
        if (s == 7'd0) return 1;
        if (s > SCALE_MAX) return int'(SCALE_MAX);
        return int'(s);
    endfunction

    function automatic int eff_width(input logic [10:0] w);
        if (w == 11'd0) return 1;
        if (w > 11'(MAX_WIDTH_DEFAULT)) return MAX_WIDTH_DEFAULT;
        return int'(w);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'h00;
        if (r < 24) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input logic op);
        int gap;
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        blue      <= fill_on ? fill : pick_byte();
        green     <= fill_on ? fill : pick_byte();
        red       <= fill_on ? fill : pick_byte();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Source pixels, with stray ticks that the block ignores
    task automatic send_pixels(input int n, input int noise_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(OP_TICK);
            send_item(OP_PIXEL);
        end
    endtask

    // Replay ticks, with stray pixels that come back rejected
    task automatic send_ticks(input int n, input int noise_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(OP_PIXEL);
            send_item(OP_TICK);
        end
    endtask

    // One source row and all of its replays
    task automatic send_row(input int noise_pct);
        int w;
        int f;
        w = eff_width(width_set);
        f = eff_scale(scale_set);
        send_pixels(w, noise_pct);
        send_ticks((f - 1) * w, noise_pct);
    endtask

    // Drop valid and wait until every predicted run has come out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (runs_outstanding != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write the selected registers back to back
    task automatic configure(input logic set_scale, input logic set_width,
                             input logic [10:0] scale_word, input logic [10:0] width_word);
        if (set_scale)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_SCALE_FACTOR;
            cfg_data  <= scale_word;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            scale_set = scale_word[6:0];
        end
        if (set_width)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_SOURCE_WIDTH;
            cfg_data  <= width_word;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            width_set = width_word;
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial
    begin : receiver
        int   run_left;
        int   cyc;
        logic stalled;
        logic calm;
        run_left = 0;
        cyc      = 0;
        stalled  = 1'b0;
        calm     = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                run_left  = 0;
            end
            cyc++;
            if (cyc % 256 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (run_left > 0)
                run_left--;
            else
            begin
                stalled  = !calm && ($urandom_range(0, 2) == 0);
                run_left = stalled ? pick_gap() + 1 : $urandom_range(0, 10);
            end
            out_stall <= stalled;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= IDLE_LIMIT)
                begin
                    $display("** pixel_replication_upscaler_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int   r;
        int   s;
        int   w;
        int   rows;
        int   noise;
        logic set_s;
        logic set_w;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SCALE_FACTOR;
        cfg_data  <= 11'd0;
        in_valid  <= 1'b0;
        operation <= OP_PIXEL;
        blue      <= 8'h00;
        green     <= 8'h00;
        red       <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Reset settings: single black pixel, then a tick outside any replay
        fill_on = 1'b1;
        fill    = 8'h00;
        send_pixels(1, 0);
        send_item(OP_TICK);
        settle();

        // Zero factor and zero width act as one; white pixel
        configure(1'b1, 1'b1, {4'hF, 7'd0}, 11'd0);
        fill = 8'hFF;
        send_pixels(1, 0);
        settle();

        // Factor 3 over two pixels, with a pixel sent into the replay
        configure(1'b1, 1'b1, 11'd3, 11'd2);
        fill_on = 1'b0;
        send_pixels(2, 0);
        send_item(OP_PIXEL);
        send_ticks(4, 0);
        settle();

        // Lower the width in the middle of a row
        configure(1'b1, 1'b1, 11'd2, 11'd6);
        send_pixels(4, 0);
        settle();
        configure(1'b0, 1'b1, 11'd0, 11'd2);
        send_pixels(1, 0);
        send_ticks((eff_scale(scale_set) - 1) * eff_width(width_set), 0);
        settle();

        // Long receiver hold-off while the sender keeps offering
        configure(1'b1, 1'b1, 11'd4, 11'd16);
        hold_req = 1'b1;
        send_row(0);
        settle();

        // Random phases: new settings, whole rows with random content and noise
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)       s = 0;
            else if (r < 14) s = 100;
            else if (r < 20) s = $urandom_range(101, 127);
            else if (r < 32) s = 1;
            else             s = $urandom_range(2, 6);
            set_s = ($urandom_range(0, 4) != 0);
            if (!set_s)
                s = int'(scale_set);
            r = $urandom_range(0, 99);
            if (eff_scale(7'(s)) >= 50) w = $urandom_range(1, 2);
            else if (r < 8)             w = 0;
            else if (r < 16)            w = 1;
            else if (r < 26)            w = $urandom_range(17, 48);
            else                        w = $urandom_range(2, 12);
            set_w = ($urandom_range(0, 4) != 0) ||
                    (eff_scale(7'(s)) * eff_width(width_set) > 300);
            configure(set_s, set_w, {4'($urandom), 7'(s)}, 11'(w));
            rows    = (eff_scale(scale_set) * eff_width(width_set) > 100) ?
                      1 : $urandom_range(1, 3);
            noise   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 15);
            in_calm = ($urandom_range(0, 3) == 0);
            repeat (rows) send_row(noise);
            settle();
        end

        // Width above the buffer size clamps to the full line; close the row
        // by lowering the width
        in_calm = 1'b0;
        configure(1'b1, 1'b1, 11'd1, 11'd2047);
        send_pixels(3, 0);
        settle();
        configure(1'b0, 1'b1, 11'd0, 11'd2);
        send_pixels(1, 0);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && runs_outstanding == 0)
            $display("** pixel_replication_upscaler_core: PASSED **");
        else
            $display("** pixel_replication_upscaler_core: FAILED **");
        $finish;
    end

endmodule
